@@ design/qrc_pkg.sv @@
// Shared types and constants for the quaternion rotate and compose block.
`default_nettype none

package qrc_pkg;

  localparam int NUM_STAGES = 5;

  localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;

  typedef enum logic {
    FUNC_ROTATE  = 1'b0,
    FUNC_COMPOSE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CFG_QUAT_W = 2'd0,
    CFG_QUAT_X = 2'd1,
    CFG_QUAT_Y = 2'd2,
    CFG_QUAT_Z = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

`default_nettype wire

@@ design/quaternion_rotate_and_compose.sv @@
// Top level of the quaternion rotate and compose block.
//
// Requests enter on in_valid/in_stall with func, in_w..in_z; results leave on
// out_valid/out_stall with out_w..out_z and saturated, one result per request,
// in request order. func 0 rotates the integer vector (in_x, in_y, in_z) by the
// configured quaternion (out_w reads 0); func 1 forms the quaternion product.
// The configured quaternion is written through cfg_we, cfg_index, cfg_data
// (index 0 w, 1 x, 2 y, 3 z); the user must write it only while no request
// is in flight, which the block itself does not enforce. Throughput is one
// request per cycle while in_stall is low. The work runs through five register
// stages (products, matrix and partial sums, vector-matrix products, final sums,
// round and saturate).
// When the receiver stalls, the held result stays and the stages behind it
// keep filling their empty slots; in_stall rises only when every stage is full.
// Reset empties the pipeline and sets the quaternion to identity (w = 1.0).
`default_nettype none

module quaternion_rotate_and_compose (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [15:0] in_w,
  input  wire logic [15:0] in_x,
  input  wire logic [15:0] in_y,
  input  wire logic [15:0] in_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_w,
  output logic [15:0]      out_x,
  output logic [15:0]      out_y,
  output logic [15:0]      out_z,
  output logic             saturated,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import qrc_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  quat_t     cfg;
  quat_t     in_q;
  quat_t     out_q;
  stage_en_t valid;
  stage_en_t en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.w <= QUAT_W_RESET;
      cfg.x <= '0;
      cfg.y <= '0;
      cfg.z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_QUAT_W: cfg.w <= cfg_data;
        CFG_QUAT_X: cfg.x <= cfg_data;
        CFG_QUAT_Y: cfg.y <= cfg_data;
        CFG_QUAT_Z: cfg.z <= cfg_data;
        default:    cfg   <= cfg;
      endcase
    end
  end

  // advance a stage when it is empty or the one after it moves
  always_comb begin
    en[LAST] = !valid[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid[LAST];

  assign in_q.w = in_w;
  assign in_q.x = in_x;
  assign in_q.y = in_y;
  assign in_q.z = in_z;

  qrc_datapath u_datapath (
    .clk       (clk),
    .en        (en),
    .func      (func_t'(func)),
    .in_q      (in_q),
    .cfg       (cfg),
    .out_q     (out_q),
    .saturated (saturated)
  );

  assign out_w = out_q.w;
  assign out_x = out_q.x;
  assign out_y = out_q.y;
  assign out_z = out_q.z;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&valid))
    else $error("input held off with an empty stage");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (valid == '0))
    else $error("pipeline not empty after reset");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(in_valid && !in_stall))
      |=> ($countones(valid) == $past($countones(valid)) - 1))
    else $error("occupancy lost or gained a request");

  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !(out_valid && !out_stall))
      |=> ($countones(valid) == $past($countones(valid)) + 1))
    else $error("accepted request not held in the pipeline");
`endif

endmodule

`default_nettype wire

@@ design/qrc_datapath.sv @@
// Five-stage arithmetic pipeline for vector rotation and quaternion product.
`default_nettype none

module qrc_datapath (
  input  wire logic              clk,
  input  wire qrc_pkg::stage_en_t en,
  input  wire qrc_pkg::func_t    func,
  input  wire qrc_pkg::quat_t    in_q,
  input  wire qrc_pkg::quat_t    cfg,
  output qrc_pkg::quat_t         out_q,
  output logic                   saturated
);
  import qrc_pkg::*;

  localparam logic signed [32:0] HALF_Q28  = 33'sd134217728;
  localparam int                 ROT_SHIFT = 27;
  localparam int                 CMP_SHIFT = 14;
  localparam logic signed [51:0] RND_ROT   = 52'sd67108864;
  localparam logic signed [51:0] RND_CMP   = 52'sd8192;
  localparam logic signed [51:0] SAT_HI    = 52'sd32767;
  localparam logic signed [51:0] SAT_LO    = -52'sd32768;

  function automatic logic [16:0] round_sat(input logic signed [51:0] v, input func_t f);
    logic signed [51:0] r;
    logic               sat;
    logic signed [15:0] q;
    if (f == FUNC_ROTATE) begin
      r = (v + RND_ROT) >>> ROT_SHIFT;
    end else begin
      r = (v + RND_CMP) >>> CMP_SHIFT;
    end
    sat = 1'b0;
    q   = r[15:0];
    if (r > SAT_HI) begin
      q   = SAT_HI[15:0];
      sat = 1'b1;
    end else if (r < SAT_LO) begin
      q   = SAT_LO[15:0];
      sat = 1'b1;
    end
    return {sat, q};
  endfunction

  // stage 0: products
  func_t              func0;
  logic signed [15:0] vx0, vy0, vz0;
  logic signed [31:0] k_cc, k_xx, k_yy, k_zz, k_xy, k_xz, k_yz, k_cx, k_cy, k_cz;
  logic signed [15:0] a [4];
  logic signed [15:0] b [4];
  logic signed [31:0] cp [4][4];

  always_comb begin
    a[0] = in_q.w; a[1] = in_q.x; a[2] = in_q.y; a[3] = in_q.z;
    b[0] = cfg.w;  b[1] = cfg.x;  b[2] = cfg.y;  b[3] = cfg.z;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      func0 <= func;
      vx0   <= in_q.x;
      vy0   <= in_q.y;
      vz0   <= in_q.z;
      k_cc  <= 32'(cfg.w) * 32'(cfg.w);
      k_xx  <= 32'(cfg.x) * 32'(cfg.x);
      k_yy  <= 32'(cfg.y) * 32'(cfg.y);
      k_zz  <= 32'(cfg.z) * 32'(cfg.z);
      k_xy  <= 32'(cfg.x) * 32'(cfg.y);
      k_xz  <= 32'(cfg.x) * 32'(cfg.z);
      k_yz  <= 32'(cfg.y) * 32'(cfg.z);
      k_cx  <= 32'(cfg.w) * 32'(cfg.x);
      k_cy  <= 32'(cfg.w) * 32'(cfg.y);
      k_cz  <= 32'(cfg.w) * 32'(cfg.z);
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          cp[i][j] <= 32'(a[i]) * 32'(b[j]);
        end
      end
    end
  end

  // stage 1: matrix entries and product sums
  func_t              func1;
  logic signed [15:0] vx1, vy1, vz1;
  logic signed [32:0] m [3][3];
  logic signed [33:0] ps [4];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      func1   <= func0;
      vx1     <= vx0;
      vy1     <= vy0;
      vz1     <= vz0;
      m[0][0] <= 33'(k_cc) - HALF_Q28 + 33'(k_xx);
      m[1][1] <= 33'(k_cc) - HALF_Q28 + 33'(k_yy);
      m[2][2] <= 33'(k_cc) - HALF_Q28 + 33'(k_zz);
      m[0][1] <= 33'(k_xy) - 33'(k_cz);
      m[0][2] <= 33'(k_xz) + 33'(k_cy);
      m[1][0] <= 33'(k_xy) + 33'(k_cz);
      m[1][2] <= 33'(k_yz) - 33'(k_cx);
      m[2][0] <= 33'(k_xz) - 33'(k_cy);
      m[2][1] <= 33'(k_yz) + 33'(k_cx);
      ps[0]   <= 34'(cp[0][0]) - 34'(cp[1][1]) - 34'(cp[2][2]) - 34'(cp[3][3]);
      ps[1]   <= 34'(cp[0][1]) + 34'(cp[1][0]) - 34'(cp[2][3]) + 34'(cp[3][2]);
      ps[2]   <= 34'(cp[0][2]) + 34'(cp[2][0]) - 34'(cp[3][1]) + 34'(cp[1][3]);
      ps[3]   <= 34'(cp[0][3]) + 34'(cp[3][0]) - 34'(cp[1][2]) + 34'(cp[2][1]);
    end
  end

  // stage 2: vector times matrix
  func_t              func2;
  logic signed [48:0] rp [3][3];
  logic signed [33:0] ps2 [4];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      func2 <= func1;
      for (int r = 0; r < 3; r++) begin
        rp[r][0] <= 49'(vx1) * 49'(m[r][0]);
        rp[r][1] <= 49'(vy1) * 49'(m[r][1]);
        rp[r][2] <= 49'(vz1) * 49'(m[r][2]);
      end
      for (int i = 0; i < 4; i++) begin
        ps2[i] <= ps[i];
      end
    end
  end

  // stage 3: final sums
  func_t              func3;
  logic signed [51:0] acc [4];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      func3 <= func2;
      if (func2 == FUNC_ROTATE) begin
        acc[0] <= '0;
        for (int r = 0; r < 3; r++) begin
          acc[r+1] <= 52'(rp[r][0]) + 52'(rp[r][1]) + 52'(rp[r][2]);
        end
      end else begin
        for (int i = 0; i < 4; i++) begin
          acc[i] <= 52'(ps2[i]);
        end
      end
    end
  end

  // stage 4: round, saturate, output register
  logic [16:0] rs [4];
  logic        sat_any;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rs[i] = round_sat(acc[i], func3);
    end
    sat_any = rs[0][16] | rs[1][16] | rs[2][16] | rs[3][16];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      out_q.w   <= rs[0][15:0];
      out_q.x   <= rs[1][15:0];
      out_q.y   <= rs[2][15:0];
      out_q.z   <= rs[3][15:0];
      saturated <= sat_any;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_quaternion_rotate_and_compose.sv @@
// Self-checking testbench for the quaternion rotate and compose block.
`default_nettype none

module tb_quaternion_rotate_and_compose;
  import qrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 7;
  localparam int PHASE_REQS     = 200;

  typedef struct packed {
    func_t              func;
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_req_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               sat;
  } quat_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [15:0] in_w = '0;
  logic [15:0] in_x = '0;
  logic [15:0] in_y = '0;
  logic [15:0] in_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_w;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_z;
  logic        saturated;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic signed [15:0] quat_w = QUAT_W_RESET;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;

  quat_req_t quat_reqs[$];
  quat_res_t results_due[$];
  int        req_total = 0;
  int        results_seen = 0;
  int        err_count = 0;
  int        quiet_cycles = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  logic      in_took = 1'b0;
  logic      in_idle_en = 1'b1;
  logic      out_idle_en = 1'b1;

  quaternion_rotate_and_compose u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .in_w      (in_w),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_w     (out_w),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] round_clip(longint acc, int sh, inout logic clip);
    longint r;
    r = (acc + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 32767) begin
      r = 32767;
      clip = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      clip = 1'b1;
    end
    return r[15:0];
  endfunction

  function automatic quat_res_t apply_quat(quat_req_t r);
    quat_res_t res;
    logic   clip;
    longint c, sx, sy, sz, iw, ix, iy, iz, cc;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    clip = 1'b0;
    c  = longint'(quat_w);
    sx = longint'(quat_x);
    sy = longint'(quat_y);
    sz = longint'(quat_z);
    iw = longint'(r.w);
    ix = longint'(r.x);
    iy = longint'(r.y);
    iz = longint'(r.z);
    if (r.func == FUNC_ROTATE) begin
      cc  = c * c - (longint'(1) << 27);
      m00 = cc + sx * sx;
      m11 = cc + sy * sy;
      m22 = cc + sz * sz;
      m01 = sx * sy - c * sz;
      m02 = sx * sz + c * sy;
      m10 = sx * sy + c * sz;
      m12 = sy * sz - c * sx;
      m20 = sx * sz - c * sy;
      m21 = sy * sz + c * sx;
      res.w = '0;
      res.x = round_clip(ix * m00 + iy * m01 + iz * m02, 27, clip);
      res.y = round_clip(ix * m10 + iy * m11 + iz * m12, 27, clip);
      res.z = round_clip(ix * m20 + iy * m21 + iz * m22, 27, clip);
    end else begin
      res.w = round_clip(iw * c - (ix * sx + iy * sy + iz * sz), 14, clip);
      res.x = round_clip(iw * sx + ix * c - iy * sz + iz * sy, 14, clip);
      res.y = round_clip(iw * sy + iy * c - iz * sx + ix * sz, 14, clip);
      res.z = round_clip(iw * sz + iz * c - ix * sy + iy * sx, 14, clip);
    end
    res.sat = clip;
    return res;
  endfunction

  // request driver: hold until taken, then advance or idle
  always @(negedge clk) begin
    quat_req_t nxt;
    logic      drive;
    if (!(in_valid && !in_took)) begin
      drive = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (in_idle_en && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 19) - 1;
      end else if (quat_reqs.size() > 0) begin
        nxt = quat_reqs.pop_front();
        drive = 1'b1;
        func <= nxt.func;
        in_w <= nxt.w;
        in_x <= nxt.x;
        in_y <= nxt.y;
        in_z <= nxt.z;
      end
      in_valid <= drive;
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    quat_req_t seen;
    quat_res_t want;
    quat_res_t got;
    logic      acted;
    acted = 1'b0;
    in_took <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen = '{func_t'(func), in_w, in_x, in_y, in_z};
        results_due.push_back(apply_quat(seen));
        acted = 1'b1;
      end
      if (out_valid && !out_stall) begin
        acted = 1'b1;
        got = '{out_w, out_x, out_y, out_z, saturated};
        if (results_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: w=%0d x=%0d y=%0d z=%0d sat=%0b",
                     got.w, got.x, got.y, got.z, got.sat);
        end else begin
          want = results_due.pop_front();
          results_seen++;
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d sat=%0b,",
                       want.w, want.x, want.y, want.z, want.sat,
                       " got w=%0d x=%0d y=%0d z=%0d sat=%0b",
                       got.w, got.x, got.y, got.z, got.sat);
          end
        end
      end
      if (acted || results_seen == req_total)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic add_req(func_t f, logic [15:0] w, logic [15:0] x, logic [15:0] y,
                         logic [15:0] z);
    quat_reqs.push_back('{f, w, x, y, z});
    req_total++;
  endtask

  task automatic write_quat(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_QUAT_W: quat_w = val;
      CFG_QUAT_X: quat_x = val;
      CFG_QUAT_Y: quat_y = val;
      CFG_QUAT_Z: quat_z = val;
    endcase
  endtask

  task automatic write_all(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    write_quat(CFG_QUAT_W, w);
    write_quat(CFG_QUAT_X, x);
    write_quat(CFG_QUAT_Y, y);
    write_quat(CFG_QUAT_Z, z);
  endtask

  task automatic drain();
    wait (results_seen == req_total);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 512) - 256);
      1: return edge_value();
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_quat_part(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 32768) - 16384);
      default: return edge_value();
    endcase
  endfunction

  initial begin
    int ph;
    int n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity quaternion after reset
    add_req(FUNC_ROTATE, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000);
    add_req(FUNC_ROTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_req(FUNC_ROTATE, 16'h8000, 16'hffff, 16'h0001, 16'hcfc7);
    add_req(FUNC_COMPOSE, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
    add_req(FUNC_COMPOSE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_req(FUNC_COMPOSE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_req(FUNC_COMPOSE, 16'h0000, 16'h4000, 16'hc000, 16'h0001);
    drain();

    // most negative quaternion: saturation
    write_all(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_req(FUNC_ROTATE, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);
    add_req(FUNC_ROTATE, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    add_req(FUNC_ROTATE, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
    add_req(FUNC_COMPOSE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_req(FUNC_COMPOSE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_req(FUNC_COMPOSE, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    drain();

    write_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_req(FUNC_ROTATE, 16'h1234, 16'h7fff, 16'h8000, 16'h7fff);
    add_req(FUNC_COMPOSE, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    add_req(FUNC_ROTATE, 16'h0000, 16'd100, 16'd200, 16'hfed4);
    drain();

    // half-scale scalar: rounding ties on odd inputs
    write_all(16'h2000, 16'h0000, 16'h0000, 16'h0000);
    add_req(FUNC_ROTATE, 16'h0000, 16'h0001, 16'hffff, 16'h0003);
    add_req(FUNC_ROTATE, 16'h0000, 16'hfffd, 16'h0005, 16'hfff9);
    add_req(FUNC_COMPOSE, 16'h0001, 16'hffff, 16'h0003, 16'hfffd);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      in_idle_en = (ph != 2) && (ph < RAND_PHASES - 1);
      out_idle_en = (ph != 2) && (ph < RAND_PHASES - 1);
      write_all(rand_quat_part(ph % 3), rand_quat_part(ph % 3),
                rand_quat_part(ph % 3), rand_quat_part(ph % 3));
      for (n = 0; n < PHASE_REQS; n++)
        add_req(func_t'($urandom_range(0, 1)), rand_field(), rand_field(),
                rand_field(), rand_field());
      drain();
    end

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
